@@ src/dtn_pkg.sv @@
// Package for the date offset normalizer: field widths, divider codes,
// reciprocal constants, calendar helper functions and the divider structs.
// Depends on nothing; used by dtn_div and date_offset_normalize.
package dtn_pkg;

  // Fixed payload widths.
  localparam int OFF_W   = 13;
  localparam int BDAY_W  = 5;
  localparam int BMON_W  = 4;
  localparam int BYEAR_W = 14;

  // Working widths. Inputs bound every offset to -4096..4095, so the raw
  // day and month sums fit 14 signed bits and the year stays within 16.
  localparam int DAY_W  = 14;
  localparam int MON_W  = 14;
  localparam int YEAR_W = 16;

  // Shared divider: dividend / quotient width and remainder width.
  localparam int DIV_W  = 16;
  localparam int REM_W  = 9;

  // Reciprocals are floor(2^RCP_SHIFT / divisor). With dividends below
  // 2^16 the scaled estimate is never above the quotient and at most one
  // below it.
  localparam int RCP_W     = 15;
  localparam int RCP_SHIFT = 17;

  typedef enum logic [1:0] {
    DIV_BY_12  = 2'd0,
    DIV_BY_400 = 2'd1,
    DIV_BY_100 = 2'd2,
    DIV_BY_7   = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic             start;
    div_sel_e         sel;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [REM_W-1:0] div_value(input div_sel_e sel);
    logic [REM_W-1:0] v;
    case (sel)
      DIV_BY_12:  v = REM_W'(12);
      DIV_BY_400: v = REM_W'(400);
      DIV_BY_100: v = REM_W'(100);
      DIV_BY_7:   v = REM_W'(7);
      default:    v = REM_W'(7);
    endcase
    return v;
  endfunction

  function automatic logic [RCP_W-1:0] div_recip(input div_sel_e sel);
    logic [RCP_W-1:0] r;
    case (sel)
      DIV_BY_12:  r = RCP_W'(10922);
      DIV_BY_400: r = RCP_W'(327);
      DIV_BY_100: r = RCP_W'(1310);
      DIV_BY_7:   r = RCP_W'(18724);
      default:    r = RCP_W'(18724);
    endcase
    return r;
  endfunction

  // Leap rule from the year taken modulo 400 (0..399).
  function automatic logic leap_from_mod(input logic [REM_W-1:0] y400);
    logic div4;
    logic cent;
    div4 = (y400[1:0] == 2'b00);
    cent = (y400 == REM_W'(100)) || (y400 == REM_W'(200)) || (y400 == REM_W'(300));
    return div4 && !cent;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

  // Month term of the weekday formula, floor(13 * (zm + 1) / 5), zm in 3..14.
  function automatic logic [5:0] zeller_month_term(input logic [3:0] zm);
    logic [5:0] t;
    case (zm)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // Clamp a signed offset to -lim..+lim.
  function automatic logic signed [DAY_W-1:0] sat_off(input logic signed [OFF_W-1:0] v,
                                                      input int lim);
    int x;
    x = int'(v);
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    return DAY_W'(x);
  endfunction

endpackage

@@ src/dtn_div.sv @@
// Shared divider by a small constant (12, 100, 400 or 7): a reciprocal
// multiply estimates the quotient and one compare and subtract corrects it.
// Depends on dtn_pkg.
module dtn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtn_pkg::div_req_t req_i,
  output dtn_pkg::div_rsp_t rsp_o
);
  import dtn_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_EST  = 2'd1;
  localparam logic [1:0] PH_FIX  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic             done_q, done_d;
  logic [DIV_W-1:0] x_q, x_d;
  logic [REM_W-1:0] dvs_q, dvs_d;
  logic [RCP_W-1:0] rcp_q, rcp_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;

  logic [DIV_W+RCP_W-1:0] prod;
  logic [DIV_W+REM_W-1:0] back;
  logic [DIV_W+REM_W-1:0] diff;
  logic [REM_W:0]         part;
  logic                   over;

  always_comb begin
    prod = x_q * rcp_q;
    back = quo_q * dvs_q;
    diff = {{REM_W{1'b0}}, x_q} - back;
    // The estimate leaves a remainder below twice the divisor.
    part = diff[REM_W:0];
    over = (part >= {1'b0, dvs_q});

    phase_d = phase_q;
    done_d  = 1'b0;
    x_d     = x_q;
    dvs_d   = dvs_q;
    rcp_d   = rcp_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      x_d     = req_i.dividend;
      dvs_d   = div_value(req_i.sel);
      rcp_d   = div_recip(req_i.sel);
      phase_d = PH_EST;
    end else begin
      case (phase_q)
        PH_EST: begin
          quo_d   = DIV_W'(prod[DIV_W+RCP_W-1:RCP_SHIFT]);
          phase_d = PH_FIX;
        end
        PH_FIX: begin
          quo_d   = quo_q + DIV_W'(over);
          rem_d   = over ? REM_W'(part - {1'b0, dvs_q}) : part[REM_W-1:0];
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    dvs_q <= dvs_d;
    rcp_q <= rcp_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = (phase_q != PH_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ src/date_offset_normalize.sv @@
// Top level of the date offset normalizer: sequencer, calendar datapath and
// output register. Depends on dtn_pkg and dtn_div.
//
// Usage: an input beat carries a base date, a signed day/month/year offset
// and cmd (0 adds the offset, 1 subtracts it). Each offset is clamped to
// +/-OFFSET_LIMIT. One output beat follows per input beat with the
// normalized date, its weekday (0 Saturday .. 6 Friday) and out_of_range,
// which is set, with every other field zero, when the final year leaves
// 1..YEAR_MAX.
// Sequence: the month wrap, the year modulo 400, the century split and the
// weekday modulo each take one pass of the shared divider, and the day walk
// steps one month forward or back at a time until the day fits its month.
// When out_of_range is set, the century split and weekday passes are skipped.
// The block works on one item at a time: in_ready_o is high only while it
// is idle. A finished result waits in the output register; a new item is
// accepted while it waits, and if the receiver still stalls when the next
// result is done, the sequencer holds until the register frees.
// Reset empties the output register and returns the sequencer to idle.
module date_offset_normalize #(
  parameter int YEAR_MAX     = 9999,
  parameter int OFFSET_LIMIT = 4095
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [dtn_pkg::BDAY_W-1:0]           base_day_i,
  input  logic [dtn_pkg::BMON_W-1:0]           base_month_i,
  input  logic [dtn_pkg::BYEAR_W-1:0]          base_year_i,
  input  logic signed [dtn_pkg::OFF_W-1:0]     offset_days_i,
  input  logic signed [dtn_pkg::OFF_W-1:0]     offset_months_i,
  input  logic signed [dtn_pkg::OFF_W-1:0]     offset_years_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [4:0]                           result_day_o,
  output logic [3:0]                           result_month_o,
  output logic [13:0]                          result_year_o,
  output logic [2:0]                           weekday_o,
  output logic                                 out_of_range_o
);
  import dtn_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MSTART = 4'd1;
  localparam logic [3:0] ST_MWAIT  = 4'd2;
  localparam logic [3:0] ST_YSTART = 4'd3;
  localparam logic [3:0] ST_YWAIT  = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_ZSTART = 4'd6;
  localparam logic [3:0] ST_ZWAIT  = 4'd7;
  localparam logic [3:0] ST_WSTART = 4'd8;
  localparam logic [3:0] ST_WWAIT  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0] state_q, state_d;

  // Working registers.
  logic signed [DAY_W-1:0]  d_q, d_d;
  logic signed [MON_W-1:0]  m_q, m_d;
  logic signed [YEAR_W-1:0] y_q, y_d;
  logic [REM_W-1:0]         y400_q, y400_d;
  logic [DIV_W-1:0]         zy_q, zy_d;
  logic [3:0]               zm_q, zm_d;
  logic                     bad_q, bad_d;
  logic [DIV_W-1:0]         wsum_q, wsum_d;
  logic [2:0]               wd_q, wd_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [4:0]  res_day_q, res_day_d;
  logic [3:0]  res_mon_q, res_mon_d;
  logic [13:0] res_year_q, res_year_d;
  logic [2:0]  res_wd_q, res_wd_d;
  logic        res_bad_q, res_bad_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dtn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Combinational helpers.
  logic signed [DAY_W-1:0]  od, om;
  logic signed [DAY_W-1:0]  oy;
  logic signed [DAY_W-1:0]  bd_ext, bm_ext;
  logic signed [YEAR_W-1:0] by_ext, oy_ext;
  logic signed [MON_W-1:0]  mm1;
  logic [MON_W-1:0]         mm1_mag;
  logic [YEAR_W-1:0]        y_mag;
  logic [4:0]               dim_cur, dim_prev;
  logic [3:0]               pm;
  logic [REM_W-1:0]         py400, ny400;
  logic                     go_fwd, go_bwd;
  logic                     year_bad;
  logic                     out_free;
  logic [DIV_W-1:0]         k_ext, j_ext;

  always_comb begin
    od     = sat_off(offset_days_i, OFFSET_LIMIT);
    om     = sat_off(offset_months_i, OFFSET_LIMIT);
    oy     = sat_off(offset_years_i, OFFSET_LIMIT);
    bd_ext = $signed({{(DAY_W-BDAY_W){1'b0}}, base_day_i});
    bm_ext = $signed({{(MON_W-BMON_W){1'b0}}, base_month_i});
    by_ext = $signed({{(YEAR_W-BYEAR_W){1'b0}}, base_year_i});
    oy_ext = {{(YEAR_W-DAY_W){oy[DAY_W-1]}}, oy};

    mm1     = m_q - MON_W'(1);
    mm1_mag = mm1[MON_W-1] ? MON_W'(~mm1 + MON_W'(1)) : mm1;
    y_mag   = y_q[YEAR_W-1] ? YEAR_W'(~y_q + YEAR_W'(1)) : y_q;

    // Current month length and the one before it, for the day walk.
    dim_cur = days_in_month(m_q[3:0], leap_from_mod(y400_q));
    pm      = (m_q[3:0] == 4'd1) ? 4'd12 : m_q[3:0] - 4'd1;
    py400   = (m_q[3:0] != 4'd1) ? y400_q :
              (y400_q == '0) ? REM_W'(399) : y400_q - REM_W'(1);
    ny400   = (y400_q == REM_W'(399)) ? '0 : y400_q + REM_W'(1);
    dim_prev = days_in_month(pm, leap_from_mod(py400));
    go_fwd  = (d_q > $signed({{(DAY_W-5){1'b0}}, dim_cur}));
    go_bwd  = (d_q <= 0);

    year_bad = (int'(y_q) < 1) || (int'(y_q) > YEAR_MAX);
    out_free = !out_valid_q || out_ready_i;
    k_ext    = DIV_W'(div_rsp.rem);
    j_ext    = div_rsp.quo;
  end

  always_comb begin
    state_d  = state_q;
    d_d      = d_q;
    m_d      = m_q;
    y_d      = y_q;
    y400_d   = y400_q;
    zy_d     = zy_q;
    zm_d     = zm_q;
    bad_d    = bad_q;
    wsum_d   = wsum_q;
    wd_d     = wd_q;

    div_req.start    = 1'b0;
    div_req.sel      = DIV_BY_12;
    div_req.dividend = '0;

    out_valid_d = out_valid_q && !out_ready_i;
    res_day_d   = res_day_q;
    res_mon_d   = res_mon_q;
    res_year_d  = res_year_q;
    res_wd_d    = res_wd_q;
    res_bad_d   = res_bad_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          d_d     = cmd_i ? bd_ext - od : bd_ext + od;
          m_d     = cmd_i ? bm_ext - om : bm_ext + om;
          y_d     = cmd_i ? by_ext - oy_ext : by_ext + oy_ext;
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        // Wrap month - 1 into 0..11 by a floor division by twelve.
        div_req.start    = 1'b1;
        div_req.sel      = DIV_BY_12;
        div_req.dividend = DIV_W'(mm1_mag);
        state_d          = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (div_rsp.done) begin
          if (!mm1[MON_W-1]) begin
            m_d = MON_W'(div_rsp.rem) + MON_W'(1);
            y_d = y_q + $signed(YEAR_W'(div_rsp.quo));
          end else if (div_rsp.rem == '0) begin
            m_d = MON_W'(1);
            y_d = y_q - $signed(YEAR_W'(div_rsp.quo));
          end else begin
            m_d = MON_W'(13) - MON_W'(div_rsp.rem);
            y_d = y_q - $signed(YEAR_W'(div_rsp.quo)) - YEAR_W'(1);
          end
          state_d = ST_YSTART;
        end
      end
      ST_YSTART: begin
        div_req.start    = 1'b1;
        div_req.sel      = DIV_BY_400;
        div_req.dividend = DIV_W'(y_mag);
        state_d          = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (div_rsp.done) begin
          // Floor modulo, so that the count stays consistent across zero.
          y400_d  = (y_q[YEAR_W-1] && div_rsp.rem != '0) ?
                    REM_W'(400) - div_rsp.rem : div_rsp.rem;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (go_fwd) begin
          d_d = d_q - $signed({{(DAY_W-5){1'b0}}, dim_cur});
          if (m_q[3:0] == 4'd12) begin
            m_d    = MON_W'(1);
            y_d    = y_q + YEAR_W'(1);
            y400_d = ny400;
          end else begin
            m_d = m_q + MON_W'(1);
          end
        end else if (go_bwd) begin
          m_d    = $signed({{(MON_W-4){1'b0}}, pm});
          y400_d = py400;
          if (m_q[3:0] == 4'd1) begin
            y_d = y_q - YEAR_W'(1);
          end
          d_d = d_q + $signed({{(DAY_W-5){1'b0}}, dim_prev});
        end else begin
          bad_d = year_bad;
          if (m_q[3:0] < 4'd3) begin
            zm_d = m_q[3:0] + 4'd12;
            zy_d = DIV_W'(y_q - YEAR_W'(1));
          end else begin
            zm_d = m_q[3:0];
            zy_d = DIV_W'(y_q);
          end
          state_d = year_bad ? ST_DONE : ST_ZSTART;
        end
      end
      ST_ZSTART: begin
        div_req.start    = 1'b1;
        div_req.sel      = DIV_BY_100;
        div_req.dividend = zy_q;
        state_d          = ST_ZWAIT;
      end
      ST_ZWAIT: begin
        if (div_rsp.done) begin
          // Remainder is the year of the century, quotient the century.
          wsum_d = DIV_W'(d_q[4:0]) + DIV_W'(zeller_month_term(zm_q)) + k_ext +
                   (k_ext >> 2) + (j_ext >> 2) + (j_ext << 2) + j_ext;
          state_d = ST_WSTART;
        end
      end
      ST_WSTART: begin
        div_req.start    = 1'b1;
        div_req.sel      = DIV_BY_7;
        div_req.dividend = wsum_q;
        state_d          = ST_WWAIT;
      end
      ST_WWAIT: begin
        if (div_rsp.done) begin
          wd_d    = div_rsp.rem[2:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_bad_d   = bad_q;
          res_day_d   = bad_q ? 5'd0  : d_q[4:0];
          res_mon_d   = bad_q ? 4'd0  : m_q[3:0];
          res_year_d  = bad_q ? 14'd0 : y_q[13:0];
          res_wd_d    = bad_q ? 3'd0  : wd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    m_q        <= m_d;
    y_q        <= y_d;
    y400_q     <= y400_d;
    zy_q       <= zy_d;
    zm_q       <= zm_d;
    bad_q      <= bad_d;
    wsum_q     <= wsum_d;
    wd_q       <= wd_d;
    res_day_q  <= res_day_d;
    res_mon_q  <= res_mon_d;
    res_year_q <= res_year_d;
    res_wd_q   <= res_wd_d;
    res_bad_q  <= res_bad_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_day_o   = res_day_q;
  assign result_month_o = res_mon_q;
  assign result_year_o  = res_year_q;
  assign weekday_o      = res_wd_q;
  assign out_of_range_o = res_bad_q;

endmodule

@@ dv/date_result_checker.sv @@
// Checker for the date offset normalizer: watches both channels, predicts each result
// and compares it field by field with what the block returns.
// Depends on dtn_pkg for the offset width.
module date_result_checker #(
  parameter int YEAR_MAX     = 9999,
  parameter int OFFSET_LIMIT = 4095
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic                             cmd_i,
  input  logic [4:0]                       base_day_i,
  input  logic [3:0]                       base_month_i,
  input  logic [13:0]                      base_year_i,
  input  logic signed [dtn_pkg::OFF_W-1:0] offset_days_i,
  input  logic signed [dtn_pkg::OFF_W-1:0] offset_months_i,
  input  logic signed [dtn_pkg::OFF_W-1:0] offset_years_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [4:0]                       result_day_i,
  input  logic [3:0]                       result_month_i,
  input  logic [13:0]                      result_year_i,
  input  logic [2:0]                       weekday_i,
  input  logic                             out_of_range_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               range_count_o
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        out_of_range;
  } date_result_t;

  date_result_t expected_dates[$];

  function automatic int clamp_offset(input logic signed [dtn_pkg::OFF_W-1:0] v);
    int x;
    x = int'(v);
    if (x > OFFSET_LIMIT) x = OFFSET_LIMIT;
    if (x < -OFFSET_LIMIT) x = -OFFSET_LIMIT;
    return x;
  endfunction

  // Length of month m in year y; the leap rule is plain divisibility, so it
  // also holds for years at or below zero.
  function automatic int month_days(input int m, input int y);
    logic leap;
    leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_result_t normalize_date(
    input logic                             subtract,
    input logic [4:0]                       bd,
    input logic [3:0]                       bm,
    input logic [13:0]                      by,
    input logic signed [dtn_pkg::OFF_W-1:0] od_raw,
    input logic signed [dtn_pkg::OFF_W-1:0] om_raw,
    input logic signed [dtn_pkg::OFF_W-1:0] oy_raw
  );
    date_result_t r;
    int d, m, y, od, om, oy, zy, zm, k, j, w;
    r  = '0;
    w  = 0;
    od = clamp_offset(od_raw);
    om = clamp_offset(om_raw);
    oy = clamp_offset(oy_raw);
    d  = int'(bd);
    m  = int'(bm);
    y  = int'(by);
    if (subtract) begin
      d -= od; m -= om; y -= oy;
    end else begin
      d += od; m += om; y += oy;
    end
    while (m < 1) begin
      m += 12; y -= 1;
    end
    while (m > 12) begin
      m -= 12; y += 1;
    end
    while (d > month_days(m, y)) begin
      d -= month_days(m, y);
      m += 1;
      if (m > 12) begin
        m = 1; y += 1;
      end
    end
    while (d <= 0) begin
      m -= 1;
      if (m < 1) begin
        m = 12; y -= 1;
      end
      d += month_days(m, y);
    end
    if (y < 1 || y > YEAR_MAX) begin
      r.out_of_range = 1'b1;
    end else begin
      // Zeller counts January and February as months 13 and 14 of the
      // previous year.
      zy = y;
      zm = m;
      if (zm < 3) begin
        zm += 12; zy -= 1;
      end
      k = zy % 100;
      j = zy / 100;
      w = (d + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      r.day     = d[4:0];
      r.month   = m[3:0];
      r.year    = y[13:0];
      r.weekday = w[2:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o  = 0;
    pending_o     = 0;
    checked_o     = 0;
    range_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    date_result_t want;
    if (!rst_ni) begin
      expected_dates.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          $error("result beat with no input beat waiting for it");
          fail_count_o++;
        end else begin
          want = expected_dates.pop_front();
          check_field("result_day", want.day, result_day_i);
          check_field("result_month", want.month, result_month_i);
          check_field("result_year", want.year, result_year_i);
          check_field("weekday", want.weekday, weekday_i);
          check_field("out_of_range", want.out_of_range, out_of_range_i);
          checked_o++;
          if (want.out_of_range) range_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_dates.push_back(normalize_date(cmd_i, base_day_i, base_month_i,
                                                base_year_i, offset_days_i,
                                                offset_months_i, offset_years_i));
      end
      pending_o = expected_dates.size();
    end
  end

endmodule

@@ dv/tb_date_offset_normalize.sv @@
// Testbench top for the date offset normalizer: clock, reset, stimulus and verdict.
// Depends on dtn_pkg, date_offset_normalize and date_result_checker.
module tb_date_offset_normalize;

  localparam int YEAR_MAX     = 9999;
  localparam int OFFSET_LIMIT = 4095;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                             in_valid;
  logic                             in_ready;
  logic                             cmd;
  logic [4:0]                       base_day;
  logic [3:0]                       base_month;
  logic [13:0]                      base_year;
  logic signed [dtn_pkg::OFF_W-1:0] offset_days;
  logic signed [dtn_pkg::OFF_W-1:0] offset_months;
  logic signed [dtn_pkg::OFF_W-1:0] offset_years;
  logic                             out_valid;
  logic                             out_ready;
  logic [4:0]                       result_day;
  logic [3:0]                       result_month;
  logic [13:0]                      result_year;
  logic [2:0]                       weekday;
  logic                             out_of_range;

  int fail_count;
  int pending;
  int checked;
  int range_count;

  // Sender state: beats sent, and whether gaps are currently suppressed.
  int  n_sent;
  int  n_directed;
  logic send_burst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  date_offset_normalize #(
    .YEAR_MAX    (YEAR_MAX),
    .OFFSET_LIMIT(OFFSET_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .base_day_i     (base_day),
    .base_month_i   (base_month),
    .base_year_i    (base_year),
    .offset_days_i  (offset_days),
    .offset_months_i(offset_months),
    .offset_years_i (offset_years),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_day_o   (result_day),
    .result_month_o (result_month),
    .result_year_o  (result_year),
    .weekday_o      (weekday),
    .out_of_range_o (out_of_range)
  );

  date_result_checker #(
    .YEAR_MAX    (YEAR_MAX),
    .OFFSET_LIMIT(OFFSET_LIMIT)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .base_day_i     (base_day),
    .base_month_i   (base_month),
    .base_year_i    (base_year),
    .offset_days_i  (offset_days),
    .offset_months_i(offset_months),
    .offset_years_i (offset_years),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_day_i   (result_day),
    .result_month_i (result_month),
    .result_year_i  (result_year),
    .weekday_i      (weekday),
    .out_of_range_i (out_of_range),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .range_count_o  (range_count)
  );

  // Sends one date beat. The task is entered and left at a falling edge. A
  // zero gap keeps valid high straight into the next beat; otherwise valid
  // drops for the drawn number of cycles first.
  task automatic send_date(input cmd_e c, input int d, input int m, input int y,
                           input int od, input int om, input int oy);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd           <= c;
    base_day      <= d[4:0];
    base_month    <= m[3:0];
    base_year     <= y[13:0];
    offset_days   <= od[12:0];
    offset_months <= om[12:0];
    offset_years  <= oy[12:0];
    in_valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Lowers valid and holds the sender until every predicted result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Stimulus: reset, a directed set of calendar corner cases, then random
  // beats, and finally the verdict.
  initial begin
    int   i;
    int   kind;
    cmd_e c;
    in_valid      = 1'b0;
    cmd           = CMD_ADD;
    base_day      = '0;
    base_month    = '0;
    base_year     = '0;
    offset_days   = '0;
    offset_months = '0;
    offset_years  = '0;
    n_sent        = 0;
    send_burst    = 1'b0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero offset at the first and last representable dates.
    send_date(CMD_ADD, 1, 1, 1, 0, 0, 0);
    send_date(CMD_ADD, 31, 12, 9999, 0, 0, 0);
    // Stepping off either end of the year range raises the range flag.
    send_date(CMD_ADD, 31, 12, 9999, 1, 0, 0);
    send_date(CMD_SUB, 1, 1, 1, 1, 0, 0);
    // Leap rules: Feb 29 into a common year, century and 400-year cases.
    send_date(CMD_ADD, 29, 2, 2000, 0, 0, 1);
    send_date(CMD_ADD, 28, 2, 1900, 1, 0, 0);
    send_date(CMD_ADD, 28, 2, 2000, 1, 0, 0);
    send_date(CMD_SUB, 1, 3, 2024, 1, 0, 0);
    // Month end overflow: Jan 31 plus one month lands in March.
    send_date(CMD_ADD, 31, 1, 2023, 0, 1, 0);
    send_date(CMD_ADD, 31, 12, 2020, 0, 1, 0);
    // Most negative offset codes are clamped to the negative limit.
    send_date(CMD_ADD, 15, 6, 6000, -4096, -4096, 0);
    send_date(CMD_SUB, 15, 6, 100, -4096, -4096, -4096);
    // Full positive and negative offsets in both directions.
    send_date(CMD_ADD, 31, 12, 5000, 4095, 4095, 4095);
    send_date(CMD_SUB, 1, 1, 5000, 4095, 4095, 4095);
    send_date(CMD_SUB, 31, 12, 1, -4095, -4095, -4095);
    // Malformed base dates are normalized like any raw sum.
    send_date(CMD_ADD, 0, 0, 2020, 0, 0, 0);
    send_date(CMD_ADD, 31, 15, 2020, 0, 0, 0);
    send_date(CMD_ADD, 31, 2, 2021, 0, 0, 0);
    // Base year outside the range, brought back in or left outside.
    send_date(CMD_ADD, 10, 5, 0, 0, 0, 1);
    send_date(CMD_SUB, 31, 15, 16383, 4095, 4095, 4095);
    // First the year dips below one during the month wrap and the day walk
    // carries it back into range; then a malformed base stays above the range.
    send_date(CMD_ADD, 1, 1, 1, 800, -13, 0);
    send_date(CMD_SUB, 31, 15, 16383, -1, -1, 4095);
    n_directed = n_sent;

    // Pause the sender until the directed results are all back.
    drain_results();

    for (i = 0; i < 1400; i++) begin
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      if (i % 350 == 349) drain_results();
      c    = cmd_e'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // Base fields in their normal ranges with offsets that mostly keep the year in
        // range and spread the day walk over short and long distances.
        send_date(c, $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 9999),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8190) - 4095
                                              : $urandom_range(0, 800) - 400,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8190) - 4095
                                              : $urandom_range(0, 48) - 24,
                  $urandom_range(0, 400) - 200);
      end else if (kind < 8) begin
        // Dates near either end of the year range, crossing it or not.
        send_date(c, $urandom_range(1, 31), $urandom_range(1, 12),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(1, 30)
                                              : $urandom_range(9970, 9999),
                  $urandom_range(0, 1600) - 800, $urandom_range(0, 60) - 30,
                  $urandom_range(0, 40) - 20);
      end else begin
        // Raw bit patterns on every field.
        send_date(c, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom());
      end
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d directed and %0d random date beats; %0d results checked.",
             n_directed, n_sent - n_directed, checked);
    $display("%0d of them had the final year outside 1..%0d.", range_count, YEAR_MAX);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: before each result it either keeps ready high or drops it,
  // waits for the result to show up, and stalls for the drawn cycles.
  initial begin
    int   stall;
    logic recv_burst;
    out_ready  = 1'b0;
    recv_burst = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk_i); while (!out_valid);
        repeat (stall) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #15000000;
    $display("Verification failed");
    $finish;
  end

endmodule
